[src/gww_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gww_pkg
// Types and constants shared by the greedy word wrap controller and datapath.
// ----------------------------------------------------------------------------
package gww_pkg;

    localparam int CNT_W = 7;
    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CNT_W-1:0]  WIDTH_RESET  = 7'd64;
    localparam logic [CNT_W-1:0]  CNT_SAT      = 7'd127;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_ONE,
        S_PREFIX,
        S_WORD
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_ONE,
        ACT_FLUSH
    } action_t;

    typedef struct packed {
        logic capture;
        logic decide;
        logic load_one;
        logic load_prefix;
        logic load_word;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    slot_free;
        logic    word_last;
    } sts_t;

endpackage

[src/gww_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gww_in_if
// Text byte channel: one byte and its end-of-text flag per beat.
// ----------------------------------------------------------------------------
interface gww_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

[src/gww_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gww_out_if
// Wrapped text channel: one output byte and its last-of-run flag per beat.
// ----------------------------------------------------------------------------
interface gww_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;

    modport source (output valid, output out_char, output run_last, input ready);
    modport sink (input valid, input out_char, input run_last, output ready);
endinterface

[src/gww_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gww_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module gww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/gww_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gww_ctrl
// Sequencer: accept a byte, decide, then drive the output beats it causes.
// ----------------------------------------------------------------------------
module gww_ctrl
    import gww_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (sts.action)
                    ACT_ONE:   state_next = S_ONE;
                    ACT_FLUSH: state_next = S_PREFIX;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_ONE:
            begin
                if (sts.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PREFIX:
            begin
                if (sts.slot_free)
                begin
                    state_next = S_WORD;
                end
            end
            S_WORD:
            begin
                if (sts.slot_free && sts.word_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            S_ONE:
            begin
                cmd.load_one = sts.slot_free;
            end
            S_PREFIX:
            begin
                cmd.load_prefix = sts.slot_free;
            end
            S_WORD:
            begin
                cmd.load_word = sts.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/gww_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gww_dp
// Datapath: line and word counters, word store, fit test and output register.
// ----------------------------------------------------------------------------
module gww_dp
    import gww_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              end_of_text,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              run_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [CNT_W-1:0] MAX_W = CNT_W'(MAX_WIDTH);

    logic [CNT_W-1:0]  width_reg;
    logic [CNT_W-1:0]  ll_reg, ll_next;
    logic [CNT_W-1:0]  wf_reg, wf_next;
    logic              buf_reg, buf_next;
    logic [CHAR_W-1:0] char_reg;
    logic              eot_reg;
    logic [CHAR_W-1:0] prefix_reg, prefix_next;
    logic [CNT_W-1:0]  flen_reg, flen_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic [CNT_W-1:0]  eff_w;
    logic [CNT_W-1:0]  wf_inc, ll_inc;
    logic              fits_cur, fits_inc;
    logic              ram_we;
    logic [CHAR_W-1:0] rd_data;
    action_t           action;
    logic              slot_free;
    logic              word_last;

    // Width out of range clamps to the legal span
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = CNT_W'(1);
        end
        else if (width_reg > MAX_W)
        begin
            eff_w = MAX_W;
        end
        else
        begin
            eff_w = width_reg;
        end
    end

    assign wf_inc = (wf_reg == CNT_SAT) ? CNT_SAT : wf_reg + CNT_W'(1);
    assign ll_inc = (ll_reg == CNT_SAT) ? CNT_SAT : ll_reg + CNT_W'(1);
    assign fits_cur = ({1'b0, ll_reg} + 8'd1 + {1'b0, wf_reg}) <= {1'b0, eff_w};
    assign fits_inc = ({1'b0, ll_reg} + 8'd1 + {1'b0, wf_inc}) <= {1'b0, eff_w};

    always_comb
    begin
        action      = ACT_NONE;
        ll_next     = ll_reg;
        wf_next     = wf_reg;
        buf_next    = buf_reg;
        prefix_next = SPACE_CODE;
        flen_next   = wf_reg;
        ram_we      = 1'b0;
        if (char_reg == SPACE_CODE)
        begin
            wf_next = '0;
            if (buf_reg)
            begin
                action      = ACT_FLUSH;
                prefix_next = fits_cur ? SPACE_CODE : NEWLINE_CODE;
                ll_next     = fits_cur ? ll_reg + CNT_W'(1) + wf_reg : wf_reg;
                buf_next    = 1'b0;
            end
        end
        else if (wf_reg == '0 && ll_reg == '0)
        begin
            action   = ACT_ONE;
            ll_next  = CNT_W'(1);
            wf_next  = CNT_W'(1);
            buf_next = 1'b0;
        end
        else if (wf_reg == '0 || buf_reg)
        begin
            // hold the byte; a held word is always shorter than the store
            ram_we    = cmd.decide && (wf_reg < MAX_W);
            wf_next   = wf_inc;
            flen_next = wf_inc;
            if (!fits_inc)
            begin
                action      = ACT_FLUSH;
                prefix_next = NEWLINE_CODE;
                ll_next     = wf_inc;
                buf_next    = 1'b0;
            end
            else
            begin
                buf_next = 1'b1;
                if (eot_reg)
                begin
                    action = ACT_FLUSH;
                end
            end
        end
        else
        begin
            action  = ACT_ONE;
            ll_next = ll_inc;
            wf_next = wf_inc;
        end
        if (eot_reg)
        begin
            ll_next  = '0;
            wf_next  = '0;
            buf_next = 1'b0;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign word_last = (CNT_W'(idx_reg) + CNT_W'(1)) == flen_reg;

    // Read address runs one ahead so rd_data always matches idx_reg
    always_comb
    begin
        if (cmd.decide)
        begin
            idx_next = '0;
        end
        else if (cmd.load_word)
        begin
            idx_next = idx_reg + AW'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    gww_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wf_reg[AW-1:0]),
        .wdata (char_reg),
        .raddr (idx_next),
        .rdata (rd_data)
    );

    always_comb
    begin
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        if (cmd.load_one)
        begin
            out_char_next  = char_reg;
            out_last_next  = 1'b1;
            out_valid_next = 1'b1;
        end
        else if (cmd.load_prefix)
        begin
            out_char_next  = prefix_reg;
            out_last_next  = 1'b0;
            out_valid_next = 1'b1;
        end
        else if (cmd.load_word)
        begin
            out_char_next  = rd_data;
            out_last_next  = word_last;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            ll_reg        <= '0;
            wf_reg        <= '0;
            buf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                width_reg <= cfg_wr_data;
            end
            if (cmd.decide)
            begin
                ll_reg  <= ll_next;
                wf_reg  <= wf_next;
                buf_reg <= buf_next;
            end
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            char_reg <= char_code;
            eot_reg  <= end_of_text;
        end
        if (cmd.decide)
        begin
            prefix_reg <= prefix_next;
            flen_reg   <= flen_next;
        end
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign sts.action    = action;
    assign sts.slot_free = slot_free;
    assign sts.word_last = word_last;
    assign out_valid     = out_valid_reg;
    assign out_char      = out_char_reg;
    assign run_last      = out_last_reg;

`ifndef NO_ASSERTIONS
    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_one || cmd.load_prefix || cmd.load_word) |-> slot_free)
        else $error("output loaded while a beat is still waiting");

    a_capture_then_decide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.decide)
        else $error("captured byte not followed by a decision");

    a_held_word_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        buf_reg |-> (wf_reg != '0) && (wf_reg < MAX_W))
        else $error("held word length outside the word store");

    a_flush_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decide && action == ACT_FLUSH) |-> (flen_next != '0))
        else $error("flush of an empty word");
`endif

endmodule

[src/greedy_word_wrap.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_word_wrap
// Re-emits a byte stream greedily wrapped to a configured line width.
// ----------------------------------------------------------------------------
// One text byte is taken per beat on text_in. A byte that gives no output
// passes through accept and decide; one that gives a single output byte
// adds a load of the output register. A byte that releases a held word goes
// through accept, decide, the separator (space or newline), then one stored
// byte per cycle while text_out is ready, from the single read port of the
// word store. A stall on text_out holds the sequencer; the output register
// keeps the last beat while the next byte is accepted. The user must write
// line_width via cfg_wr_en / cfg_wr_data while idle; this is not enforced.
// ----------------------------------------------------------------------------
module greedy_word_wrap
    import gww_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    gww_in_if.sink            text_in,
    gww_out_if.source         text_out
);

    cmd_t cmd;
    sts_t sts;

    gww_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text_in.valid),
        .in_ready (text_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gww_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .char_code   (text_in.char_code),
        .end_of_text (text_in.end_of_text),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (text_out.valid),
        .out_ready   (text_out.ready),
        .out_char    (text_out.out_char),
        .run_last    (text_out.run_last)
    );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the greedy word wrap block. Text bytes go in as
// bursts of words, spaces and odd bytes over several line widths. An in-bench
// model of the wrapping rules predicts every output beat, and each beat taken
// from text_out is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import gww_pkg::*;

    localparam int MAX_W      = 64;
    localparam int CLK_PERIOD = 12;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 80;
    localparam int RAND_ITEMS = 200;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } wrap_beat_t;

    class wrap_scoreboard;
        logic [CNT_W-1:0]  width_reg;
        int unsigned       line_len;
        int unsigned       word_cnt;
        bit                holding;
        logic [CHAR_W-1:0] word_buf [MAX_W];
        logic [CHAR_W-1:0] run_bytes [$];
        wrap_beat_t        wrapped_text [$];
        int                errors;

        function new();
            width_reg = WIDTH_RESET;
            line_len  = 0;
            word_cnt  = 0;
            holding   = 0;
            errors    = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > MAX_W)
                return MAX_W;
            return width_reg;
        endfunction

        function int unsigned sat_cnt(input int unsigned v);
            return (v > CNT_SAT) ? CNT_SAT : v;
        endfunction

        function bit held_word_fits();
            return line_len + 1 + word_cnt <= eff_width();
        endfunction

        function void push_held_word();
            for (int i = 0; i < word_cnt && i < MAX_W; i++)
                run_bytes.push_back(word_buf[i]);
        endfunction

        // Release the held word after a space or, if it no longer fits, a newline
        function void release_word();
            if (held_word_fits())
            begin
                run_bytes.push_back(SPACE_CODE);
                line_len = sat_cnt(line_len + 1 + word_cnt);
            end
            else
            begin
                run_bytes.push_back(NEWLINE_CODE);
                line_len = word_cnt;
            end
            push_held_word();
            holding = 0;
        endfunction

        function void note_text_byte(input logic [CHAR_W-1:0] c, input logic eot);
            run_bytes.delete();
            if (c == SPACE_CODE)
            begin
                if (holding)
                    release_word();
                word_cnt = 0;
            end
            else if (word_cnt == 0 && line_len == 0)
            begin
                run_bytes.push_back(c);
                line_len = 1;
                word_cnt = 1;
                holding  = 0;
            end
            else if (word_cnt == 0 || holding)
            begin
                holding = 1;
                if (word_cnt < MAX_W)
                    word_buf[word_cnt] = c;
                word_cnt = sat_cnt(word_cnt + 1);
                if (!held_word_fits())
                begin
                    run_bytes.push_back(NEWLINE_CODE);
                    push_held_word();
                    line_len = word_cnt;
                    holding  = 0;
                end
            end
            else
            begin
                run_bytes.push_back(c);
                line_len = sat_cnt(line_len + 1);
                word_cnt = sat_cnt(word_cnt + 1);
            end

            if (eot)
            begin
                if (holding)
                    release_word();
                line_len = 0;
                word_cnt = 0;
                holding  = 0;
            end

            foreach (run_bytes[i])
                wrapped_text.push_back('{ch: run_bytes[i], last: (i == run_bytes.size() - 1)});
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 40)
                $display("%0t ns  mismatch: %s", $realtime, msg);
        endtask

        task check_out_byte(input logic [CHAR_W-1:0] c, input logic last);
            wrap_beat_t exp_beat;
            if (wrapped_text.size() == 0)
            begin
                report($sformatf("unexpected beat char=%0d last=%0b", c, last));
                return;
            end
            exp_beat = wrapped_text.pop_front();
            if (c !== exp_beat.ch)
                report($sformatf("out_char %0d, predicted %0d", c, exp_beat.ch));
            if (last !== exp_beat.last)
                report($sformatf("run_last %0b, predicted %0b (char %0d)",
                                 last, exp_beat.last, exp_beat.ch));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;

    gww_in_if  text_in_bus ();
    gww_out_if text_out_bus ();

    wrap_scoreboard wrap_sb;

    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;

    greedy_word_wrap #(
        .MAX_WIDTH (MAX_W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .text_in     (text_in_bus),
        .text_out    (text_out_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #(CLK_PERIOD / 2.0) clk = ~clk;
    end

    // Receiver: switch between no stalls, short frequent stalls and long rare ones
    initial
    begin
        int stall_left;
        int mode;
        int mode_left;
        stall_left = 0;
        mode = 0;
        mode_left = 0;
        text_out_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                text_out_bus.ready = 1'b0;
                stall_left--;
            end
            else if (mode == 1 && $urandom_range(0, 3) == 0)
            begin
                text_out_bus.ready = 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else if (mode == 2 && $urandom_range(0, 9) == 0)
            begin
                text_out_bus.ready = 1'b0;
                stall_left = $urandom_range(4, 19);
            end
            else
            begin
                text_out_bus.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && text_out_bus.valid && text_out_bus.ready)
            wrap_sb.check_out_byte(text_out_bus.out_char, text_out_bus.run_last);
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((text_in_bus.valid && text_in_bus.ready) ||
                (text_out_bus.valid && text_out_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic idle_gap(input int unsigned cycles);
        text_in_bus.valid = 1'b0;
        repeat (cycles)
        begin
            text_in_bus.char_code   = CHAR_W'($urandom_range(0, 255));
            text_in_bus.end_of_text = 1'($urandom_range(0, 1));
            @(negedge clk);
        end
    endtask

    // Drive one beat from a falling edge; valid stays high for a following beat
    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eot);
        bit taken;
        if (burst_left == 0)
        begin
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
        end
        text_in_bus.valid       = 1'b1;
        text_in_bus.char_code   = c;
        text_in_bus.end_of_text = eot;
        taken = 0;
        while (!taken)
        begin
            @(posedge clk);
            if (text_in_bus.ready)
            begin
                taken = 1;
                wrap_sb.note_text_byte(c, eot);
            end
        end
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit eot_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_last && (i == s.len() - 1));
    endtask

    function automatic logic [CHAR_W-1:0] rand_letter();
        logic [CHAR_W-1:0] v;
        do
            v = CHAR_W'($urandom_range(0, 255));
        while (v == SPACE_CODE);
        return v;
    endfunction

    task automatic send_word(input int unsigned len, input bit eot_last);
        for (int i = 0; i < len; i++)
            send_byte(rand_letter(), eot_last && (i == len - 1));
    endtask

    // Drain every predicted beat, then let the sequencer settle before a write
    task automatic settle_and_write_width(input logic [CNT_W-1:0] w);
        idle_gap(0);
        text_in_bus.valid = 1'b0;
        while (wrap_sb.wrapped_text.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT)
            @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = w;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cfg_wr_data = CNT_W'($urandom_range(0, 127));
        wrap_sb.width_reg = w;
    endtask

    initial
    begin
        int unsigned       phase_no;
        int unsigned       phase_end;
        int unsigned       roll;
        int unsigned       w;
        int unsigned       len;
        int unsigned       n_sp;
        logic [CNT_W-1:0]  next_width;

        wrap_sb = new();
        items_sent = 0;
        burst_left = 0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        text_in_bus.valid       = 1'b0;
        text_in_bus.char_code   = '0;
        text_in_bus.end_of_text = 1'b0;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: byte extremes at the reset width
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Width zero acts as one: leading spaces, then a word forced onto a new line
        settle_and_write_width(7'd0);
        send_text("  a bc", 1'b1);
        // Held word fits; next one is left held across a width change
        settle_and_write_width(7'd8);
        send_text("ab cd ef", 1'b0);
        settle_and_write_width(7'd4);
        send_byte(SPACE_CODE, 1'b0);
        send_byte(SPACE_CODE, 1'b1);
        // Width above the maximum; end of text flushes a held word
        settle_and_write_width(7'd127);
        send_text("x y", 1'b1);

        phase_no = 0;
        phase_end = 0;
        items_sent = 0;
        while (items_sent < RAND_ITEMS)
        begin
            case (phase_no)
                0: next_width = 7'd1;
                1: next_width = CNT_W'(MAX_W);
                default:
                begin
                    roll = $urandom_range(0, 9);
                    if (roll == 0)
                        next_width = 7'd0;
                    else if (roll == 1)
                        next_width = 7'd1;
                    else if (roll == 2)
                        next_width = CNT_W'(MAX_W);
                    else if (roll == 3)
                        next_width = CNT_W'($urandom_range(MAX_W + 1, 127));
                    else
                        next_width = CNT_W'($urandom_range(2, 20));
                end
            endcase
            settle_and_write_width(next_width);
            w = wrap_sb.eff_width();

            // One very long word drives both counters into saturation
            if (phase_no == 3)
            begin
                send_word(130, 1'b0);
                send_byte(SPACE_CODE, 1'b0);
                send_word(3, 1'b1);
            end

            phase_end = items_sent + $urandom_range(12, 40);
            while (items_sent < phase_end)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 12)
                begin
                    send_byte(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70)
                        len = $urandom_range(1, w);
                    else if (roll < 90)
                        len = $urandom_range(1, w + 3);
                    else
                        len = $urandom_range(1, 2);
                    send_word(len, $urandom_range(0, 7) == 0);
                    n_sp = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 1;
                    for (int i = 0; i < n_sp; i++)
                        send_byte(SPACE_CODE,
                                  (i == n_sp - 1) && ($urandom_range(0, 19) == 0));
                end
            end
            phase_no++;
        end

        idle_gap(0);
        text_in_bus.valid = 1'b0;
        while (wrap_sb.wrapped_text.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT)
            @(negedge clk);

        if (wrap_sb.errors == 0 && wrap_sb.wrapped_text.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
src/gww_pkg.sv
src/gww_in_if.sv
src/gww_out_if.sv
src/gww_ram.sv
src/gww_ctrl.sv
src/gww_dp.sv
src/greedy_word_wrap.sv
tb/sv/tb_top.sv
